@@ rtl/scf_pkg.sv @@
// shared types and constants for the serial command framer
// no dependencies; imported by every module of the block
package scf_pkg;

  // item opcodes
  localparam logic OP_START   = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  // fixed frame bytes
  localparam logic [7:0] HEAD_A = 8'hA5;
  localparam logic [7:0] HEAD_B = 8'h7F;
  localparam logic [7:0] TAIL_A = 8'h7F;
  localparam logic [7:0] TAIL_B = 8'h5A;

  // byte positions inside a frame
  localparam int unsigned POS_W = 4;
  localparam logic [POS_W-1:0] POS_HEAD_A = 4'd0;
  localparam logic [POS_W-1:0] POS_HEAD_B = 4'd1;
  localparam logic [POS_W-1:0] POS_FLOOR  = 4'd2;
  localparam logic [POS_W-1:0] POS_ROOM   = 4'd3;
  localparam logic [POS_W-1:0] POS_CMD    = 4'd4;
  localparam logic [POS_W-1:0] POS_DATA   = 4'd5;  // length on start, byte on payload
  localparam logic [POS_W-1:0] POS_CHK    = 4'd6;
  localparam logic [POS_W-1:0] POS_TAIL_A = 4'd7;
  localparam logic [POS_W-1:0] POS_TAIL_B = 4'd8;

  // default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // one classified work entry handed from front to back
  typedef struct packed {
    logic       is_start;
    logic [7:0] floor_id;
    logic [7:0] room_id;
    logic [7:0] cmd_id;
    logic [7:0] data;      // payload_len for start, payload byte otherwise
    logic       trailer;   // append checksum and tail after data
    logic [7:0] chk;
  } entry_t;

endpackage

@@ rtl/scf_front.sv @@
// front part: accepts input items, tracks frame state and checksum
// depends on scf_pkg
module scf_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic            in_op,
  input  logic [7:0]      in_floor_id,
  input  logic [7:0]      in_room_id,
  input  logic [7:0]      in_cmd_id,
  input  logic [7:0]      in_payload_len,
  input  logic [7:0]      in_payload_byte,
  output logic            push,
  output scf_pkg::entry_t push_entry
);
  import scf_pkg::*;

  logic       frame_open_r, frame_open_nxt;
  logic [7:0] bytes_left_r, bytes_left_nxt;
  logic [7:0] running_sum_r, running_sum_nxt;

  logic [7:0] start_sum;
  logic [7:0] pay_sum;
  logic [7:0] pay_left;
  logic       pay_ok;

  assign start_sum = in_floor_id + in_room_id + in_cmd_id + in_payload_len;
  assign pay_sum   = running_sum_r + in_payload_byte;
  assign pay_left  = bytes_left_r - 8'd1;
  assign pay_ok    = frame_open_r && (bytes_left_r != 8'd0);

  // classify the item and compute the next frame state
  always_comb begin
    frame_open_nxt  = frame_open_r;
    bytes_left_nxt  = bytes_left_r;
    running_sum_nxt = running_sum_r;
    push            = 1'b0;
    push_entry      = '0;
    if (accept) begin
      if (in_op == OP_START) begin
        push                = 1'b1;
        push_entry.is_start = 1'b1;
        push_entry.floor_id = in_floor_id;
        push_entry.room_id  = in_room_id;
        push_entry.cmd_id   = in_cmd_id;
        push_entry.data     = in_payload_len;
        push_entry.trailer  = (in_payload_len == 8'd0);
        push_entry.chk      = ~start_sum + 8'd1;
        running_sum_nxt     = start_sum;
        bytes_left_nxt      = in_payload_len;
        frame_open_nxt      = (in_payload_len != 8'd0);
      end else if (pay_ok) begin
        push                = 1'b1;
        push_entry.data     = in_payload_byte;
        push_entry.trailer  = (pay_left == 8'd0);
        push_entry.chk      = ~pay_sum + 8'd1;
        running_sum_nxt     = pay_sum;
        bytes_left_nxt      = pay_left;
        frame_open_nxt      = (pay_left != 8'd0);
      end
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r  <= 1'b0;
      bytes_left_r  <= 8'd0;
      running_sum_r <= 8'd0;
    end else begin
      frame_open_r  <= frame_open_nxt;
      bytes_left_r  <= bytes_left_nxt;
      running_sum_r <= running_sum_nxt;
    end
  end

endmodule

@@ rtl/scf_queue.sv @@
// short queue of classified entries between front and back
// depends on scf_pkg
module scf_queue #(
  parameter int unsigned DEPTH = scf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  scf_pkg::entry_t push_entry,
  output logic            full,
  output logic            head_valid,
  output scf_pkg::entry_t head_entry,
  input  logic            pop
);
  import scf_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  entry_t           slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full       = (count_r == CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head_entry = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/scf_back.sv @@
// back part: expands queued entries into frame bytes, one per cycle unless out_ready stalls it
// depends on scf_pkg
module scf_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  scf_pkg::entry_t head_entry,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_tx_byte,
  output logic            out_run_last,
  output logic            out_frame_end
);
  import scf_pkg::*;

  logic [POS_W-1:0] step_r, step_nxt;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] last_pos;
  logic [7:0]       cur_byte;
  logic             is_last;
  logic             load;

  logic             out_valid_r;
  logic [7:0]       tx_byte_r;
  logic             run_last_r;
  logic             frame_end_r;

  // payload entries begin at the data position
  assign pos      = head_entry.is_start ? step_r : step_r + POS_DATA;
  assign last_pos = head_entry.trailer ? POS_TAIL_B : POS_DATA;
  assign is_last  = (pos == last_pos);
  assign load     = head_valid && (!out_valid_r || out_ready);
  assign pop      = load && is_last;

  // byte at the current position
  always_comb begin
    case (pos)
      POS_HEAD_A: cur_byte = HEAD_A;
      POS_HEAD_B: cur_byte = HEAD_B;
      POS_FLOOR:  cur_byte = head_entry.floor_id;
      POS_ROOM:   cur_byte = head_entry.room_id;
      POS_CMD:    cur_byte = head_entry.cmd_id;
      POS_DATA:   cur_byte = head_entry.data;
      POS_CHK:    cur_byte = head_entry.chk;
      POS_TAIL_A: cur_byte = TAIL_A;
      POS_TAIL_B: cur_byte = TAIL_B;
      default:    cur_byte = TAIL_B;
    endcase
  end

  // step counter within the current entry
  always_comb begin
    step_nxt = step_r;
    if (load) begin
      step_nxt = is_last ? '0 : step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (load) begin
      tx_byte_r   <= cur_byte;
      run_last_r  <= is_last;
      frame_end_r <= (pos == POS_TAIL_B);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_tx_byte   = tx_byte_r;
  assign out_run_last  = run_last_r;
  assign out_frame_end = frame_end_r;

endmodule

@@ rtl/serial_command_framer_unit.sv @@
// top level of the serial command framer: front, queue and back
// depends on scf_pkg, scf_front, scf_queue, scf_back
//
//  channel  ports                                   transfer
//  in       in_valid/in_ready, in_op, in_floor_id,  one start or payload item
//           in_room_id, in_cmd_id, in_payload_len,
//           in_payload_byte
//  out      out_valid/out_ready, out_tx_byte,       one frame byte
//           out_run_last, out_frame_end
//
// the front takes one item per cycle while the queue has room; the back
// emits one byte per cycle unless out_ready stalls it; a start item expands
// to 6 or 9 bytes, a payload item to 1 or 4 (the last closing the frame).
// an item's bytes pass through the queue and the output register. reset
// clears frame state, queue pointers and output valid flag. either side
// may stall on its own; the queue absorbs up to QUEUE_DEPTH pending items.
module serial_command_framer_unit #(
  parameter int unsigned QUEUE_DEPTH = scf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_op,
  input  logic [7:0] in_floor_id,
  input  logic [7:0] in_room_id,
  input  logic [7:0] in_cmd_id,
  input  logic [7:0] in_payload_len,
  input  logic [7:0] in_payload_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_tx_byte,
  output logic       out_run_last,
  output logic       out_frame_end
);
  import scf_pkg::*;

  logic   accept;
  logic   push;
  entry_t push_entry;
  logic   full;
  logic   head_valid;
  entry_t head_entry;
  logic   pop;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  // classify items and keep the running checksum
  scf_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .in_op           (in_op),
    .in_floor_id     (in_floor_id),
    .in_room_id      (in_room_id),
    .in_cmd_id       (in_cmd_id),
    .in_payload_len  (in_payload_len),
    .in_payload_byte (in_payload_byte),
    .push            (push),
    .push_entry      (push_entry)
  );

  // decoupling queue
  scf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop)
  );

  // byte sequencer and output register
  scf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (head_valid),
    .head_entry    (head_entry),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_tx_byte   (out_tx_byte),
    .out_run_last  (out_run_last),
    .out_frame_end (out_frame_end)
  );

endmodule
